>>> design/srpb_pkg.sv
package srpb_pkg;

  localparam int FB_WORDS_DEF = 1048576;

  // full width of the unwrapped word offset: 13-bit block index and 9-bit in-block offset
  localparam int OFF_FULL_W = 22;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [10:0] FB_WIDTH_RST  = 11'd448;
  localparam logic [10:0] FB_HEIGHT_RST = 11'd720;

  // x/15 for x <= 225 as (x * 137) >> 11
  localparam logic [7:0] DIV15_MUL   = 8'd137;
  localparam int         DIV15_SHIFT = 11;

  typedef enum logic [1:0] {
    REG_FB_WIDTH   = 2'd0,
    REG_FB_HEIGHT  = 2'd1,
    REG_FRAME_OPEN = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic              func;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [3:0]        red;
    logic [3:0]        green;
    logic [3:0]        blue;
    logic [3:0]        alpha;
  } in_item_t;

  typedef struct packed {
    logic        written;
    logic [19:0] word_offset;
    logic [15:0] pixel_word;
  } out_item_t;

  function automatic logic [3:0] mix_chan(input logic [3:0] oldc, input logic [3:0] newc,
                                          input logic [3:0] a);
    logic [8:0]  sum;
    logic [16:0] prod;
    begin
      sum  = 9'(newc * a) + 9'(oldc * (4'd15 - a));
      prod = 17'(sum * DIV15_MUL);
      mix_chan = prod[DIV15_SHIFT +: 4];
    end
  endfunction

endpackage

>>> design/srpb_ram.sv
module srpb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a read at the address being written returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/swizzled_rgba4444_pixel_blender_unit.sv
// start beats pass s1_valid_r, then out_strobe_r; one pixel per cycle when not busy
// the frame store is a single-port-write ram read in the cycle before the blend,
// with the previous pixel forwarded when both hit the same word
// reset: registers take their reset values and busy stays high while all FB_WORDS words
// (1048576 by default) of the store are cleared, one word per cycle
// results are not flow controlled: out_strobe marks each one for a single cycle
module swizzled_rgba4444_pixel_blender_unit #(
  parameter int FB_WORDS = srpb_pkg::FB_WORDS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  srpb_pkg::in_item_t                   in_item,
  output logic                                 out_strobe,
  output srpb_pkg::out_item_t                  out_item,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [srpb_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [srpb_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [srpb_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                 pready
);

  import srpb_pkg::*;

  // store depth must be a power of two, which the block does not enforce; the wrap is then a mask
  localparam int AW = $clog2(FB_WORDS);
  localparam logic [OFF_FULL_W-1:0] OFF_MASK = OFF_FULL_W'(FB_WORDS - 1);
  localparam logic [AW-1:0] CLR_LAST = AW'(FB_WORDS - 1);

  // configuration
  logic [10:0] fb_width_r;
  logic [10:0] fb_height_r;
  logic        frame_open_r;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  // clearing pass
  logic          clearing_r;
  logic [AW-1:0] clr_addr_r;

  // accept stage
  logic                  accept;
  logic                  acc_hit;
  logic [10:0]           x;
  logic [10:0]           y;
  logic [8:0]            pitch;
  logic [12:0]           ypart;
  logic [12:0]           blk;
  logic [OFF_FULL_W-1:0] acc_off;

  // blend stage
  logic                  s1_valid_r;
  logic                  s1_hit_r;
  logic                  s1_func_r;
  logic [OFF_FULL_W-1:0] s1_off_r;
  logic [3:0]            s1_red_r;
  logic [3:0]            s1_green_r;
  logic [3:0]            s1_blue_r;
  logic [3:0]            s1_alpha_r;
  logic [15:0]           rd_data;
  logic [15:0]           old_word;
  logic [15:0]           new_word;
  logic [4:0]            alpha_sum;

  // result stage, also the forwarding source
  logic                  out_strobe_r;
  out_item_t             out_item_r;
  logic [OFF_FULL_W-1:0] fwd_off_r;

  // ram port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_width_r   <= FB_WIDTH_RST;
      fb_height_r  <= FB_HEIGHT_RST;
      frame_open_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FB_WIDTH:   fb_width_r   <= pwdata[10:0];
        REG_FB_HEIGHT:  fb_height_r  <= pwdata[10:0];
        REG_FRAME_OPEN: frame_open_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_FB_WIDTH:   prdata = {21'b0, fb_width_r};
      REG_FB_HEIGHT:  prdata = {21'b0, fb_height_r};
      REG_FRAME_OPEN: prdata = {31'b0, frame_open_r};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == CLR_LAST) begin
        clearing_r <= 1'b0;
      end
    end
  end

  assign busy   = clearing_r;
  assign accept = start & ~busy;

  // bounds check and block-linear offset
  always_comb begin
    acc_hit = frame_open_r & ~in_item.pos_x[15] & ~in_item.pos_y[15]
            & (in_item.pos_x[14:0] < {4'b0, fb_width_r})
            & (in_item.pos_y[14:0] < {4'b0, fb_height_r});
    x       = in_item.pos_x[10:0];
    y       = in_item.pos_y[10:0];
    pitch   = {fb_width_r[10:5], 3'b0};
    ypart   = y[10:7] * pitch;
    blk     = 13'(y[6:4]) + {4'b0, x[10:5], 3'b0} + ypart;
    acc_off = {blk, y[3], x[4], y[2:1], x[3], y[0], x[2:0]} & OFF_MASK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_hit_r   <= acc_hit;
      s1_func_r  <= in_item.func;
      s1_off_r   <= acc_off;
      s1_red_r   <= in_item.red;
      s1_green_r <= in_item.green;
      s1_blue_r  <= in_item.blue;
      s1_alpha_r <= in_item.alpha;
    end
  end

  // the word written by the pixel ahead, now in the result stage, is not yet in the ram read data
  always_comb begin
    if (out_strobe_r && out_item_r.written && (fwd_off_r == s1_off_r)) begin
      old_word = out_item_r.pixel_word;
    end else begin
      old_word = rd_data;
    end
    alpha_sum = {1'b0, old_word[15:12]} + {1'b0, s1_alpha_r};
    if (s1_func_r) begin
      new_word[3:0]   = mix_chan(old_word[3:0],  s1_red_r,   s1_alpha_r);
      new_word[7:4]   = mix_chan(old_word[7:4],  s1_green_r, s1_alpha_r);
      new_word[11:8]  = mix_chan(old_word[11:8], s1_blue_r,  s1_alpha_r);
      new_word[15:12] = alpha_sum[4] ? 4'hF : alpha_sum[3:0];
    end else begin
      new_word = {s1_alpha_r, s1_blue_r, s1_green_r, s1_red_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      fwd_off_r <= s1_off_r;
      if (s1_hit_r) begin
        out_item_r.written     <= 1'b1;
        out_item_r.word_offset <= s1_off_r[19:0];
        out_item_r.pixel_word  <= new_word;
      end else begin
        out_item_r <= '0;
      end
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  always_comb begin
    if (clearing_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_valid_r & s1_hit_r;
      ram_waddr = s1_off_r[AW-1:0];
      ram_wdata = new_word;
    end
  end

  srpb_ram #(
    .WIDTH(16),
    .DEPTH(FB_WORDS)
  ) u_frame_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(acc_off[AW-1:0]),
    .rdata(rd_data)
  );

endmodule
